/* rtl/rwpr_pkg.sv */
// ---------------------------------------------------------------------------
// rwpr_pkg
// Shared types and constants for the rolling window percent rank block:
// item payloads, controller states and the command/status bundles.
// ---------------------------------------------------------------------------
package rwpr_pkg;

  localparam int SAMPLE_BITS     = 32;
  localparam int WINDOW_MAX_DEF  = 64;
  localparam int LEN_BITS        = 7;
  localparam int RANK_BITS       = 8;
  localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd10;
  localparam logic [LEN_BITS-1:0] RUN_SAT   = 7'd127;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_finite;
    logic                          series_start;
  } in_item_t;

  typedef struct packed {
    logic [RANK_BITS-1:0] rank_doubled_count;
    logic                 rank_valid;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // take the input item, store it, set up the scan
    logic issue;    // read the next older window entry
    logic load;     // move the result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic item_ok;    // rank defined so far, scan needed
    logic scan_done;  // no more window entries to read
    logic out_free;   // output register can take a result this cycle
  } sts_t;

endpackage

/* rtl/rolling_window_percent_rank.sv */
// ---------------------------------------------------------------------------
// rolling_window_percent_rank
// Rank of each sample among the trailing window_length samples, with ties
// counted as half; reports 2*less + equal or an invalid mark.
// ---------------------------------------------------------------------------
// One item is in flight at a time. An item whose rank is defined is accepted
// in ST_IDLE, scans the older window entries in ST_SCAN and enters the output
// register from ST_FINISH; an item whose rank is undefined (not finite, a
// short series, a not-finite sample in the window, or a window length of
// zero or above WINDOW_MAX) goes from ST_IDLE straight to ST_FINISH.
// The scan is paced by the single read port of the sample store,
// which returns one older window entry per cycle. The output register holds
// a finished result while the next item is already being worked on; a
// result still waiting there when the next one finishes holds the block in
// its finish cycle. window_length is written on cfg_wr_en and must only be
// changed while the block is idle. The sample store has no reset; only
// entries written in the current series are ever read.
module rolling_window_percent_rank #(
  parameter int WINDOW_MAX = rwpr_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rwpr_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rwpr_pkg::out_item_t           out_item,
  input  logic                          cfg_wr_en,
  input  logic [rwpr_pkg::LEN_BITS-1:0] cfg_wr_data
);
  import rwpr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rwpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rwpr_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_item    (out_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

  // the input side is closed in the cycle after an accepted item
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous item still in progress");

  // an undefined rank carries a zero count
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.rank_valid) |-> (out_item.rank_doubled_count == '0))
    else $error("invalid rank with nonzero count");

  // the current sample always ties with itself, so a defined rank is nonzero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.rank_valid) |-> (out_item.rank_doubled_count != '0))
    else $error("valid rank with zero count");

  // the scan never overlaps a new load of the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (!cmd.load && !cmd.accept))
    else $error("scan read issued alongside accept or load");

endmodule

/* rtl/rwpr_ctrl.sv */
// ---------------------------------------------------------------------------
// rwpr_ctrl
// Sequencer: accepts one item, walks the window through the datapath's
// read port for a defined rank, then hands the result to the output register.
// ---------------------------------------------------------------------------
module rwpr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rwpr_pkg::sts_t sts,
  output rwpr_pkg::cmd_t cmd
);
  import rwpr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.item_ok ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        // the last read is counted in the cycle that sees scan_done
        if (sts.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.accept = 1'b0;
    cmd.issue  = 1'b0;
    cmd.load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_SCAN: begin
        cmd.issue = !sts.scan_done;
      end
      ST_FINISH: begin
        cmd.load = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

/* rtl/rwpr_datapath.sv */
// ---------------------------------------------------------------------------
// rwpr_datapath
// Sample store, finite run tracking, window length register, scan counters
// and the output register.
// ---------------------------------------------------------------------------
module rwpr_datapath #(
  parameter int WINDOW_MAX = rwpr_pkg::WINDOW_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rwpr_pkg::in_item_t                 in_item,
  input  logic                               cfg_wr_en,
  input  logic [rwpr_pkg::LEN_BITS-1:0]      cfg_wr_data,
  input  rwpr_pkg::cmd_t                     cmd,
  output rwpr_pkg::sts_t                     sts,
  output rwpr_pkg::out_item_t                out_item,
  output logic                               out_valid,
  input  logic                               out_stall
);
  import rwpr_pkg::*;

  localparam int AW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW  = $clog2(WINDOW_MAX + 1);
  localparam int SW  = (CW + 2 > RANK_BITS) ? CW + 2 : RANK_BITS;
  localparam logic [AW-1:0] ADDR_LAST = AW'(WINDOW_MAX - 1);

  logic signed [SAMPLE_BITS-1:0] sample_mem [WINDOW_MAX];

  logic [LEN_BITS-1:0]           len_r;
  logic [AW-1:0]                 wpos_r;
  logic [LEN_BITS-1:0]           run_r;
  logic [AW-1:0]                 rd_addr_r;
  logic [LEN_BITS-1:0]           rem_r;
  logic                          rd_vld_r;
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic signed [SAMPLE_BITS-1:0] cur_r;
  logic [CW-1:0]                 less_r;
  logic [CW-1:0]                 eq_r;
  logic                          ok_r;
  out_item_t                     out_item_r;
  logic                          out_valid_r;

  logic [AW-1:0]       pos_eff;
  logic [AW-1:0]       pos_inc;
  logic [AW-1:0]       rd_addr_nxt;
  logic [LEN_BITS-1:0] run_eff;
  logic [LEN_BITS-1:0] run_nxt;
  logic                len_ok;
  logic                item_ok;
  logic [SW-1:0]       rank_sum;

  // a series start restarts the store at entry zero
  assign pos_eff     = in_item.series_start ? '0 : wpos_r;
  assign pos_inc     = (pos_eff == ADDR_LAST) ? '0 : pos_eff + AW'(1);
  assign rd_addr_nxt = (rd_addr_r == '0) ? ADDR_LAST : rd_addr_r - AW'(1);

  // run of consecutive finite samples in this series, current included
  assign run_eff = in_item.series_start ? '0 : run_r;
  always_comb begin
    if (!in_item.sample_finite) begin
      run_nxt = '0;
    end else if (run_eff == RUN_SAT) begin
      run_nxt = RUN_SAT;
    end else begin
      run_nxt = run_eff + LEN_BITS'(1);
    end
  end

  assign len_ok  = (len_r != '0) && (32'(len_r) <= 32'(WINDOW_MAX));
  assign item_ok = in_item.sample_finite && len_ok && (run_nxt >= len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else if (cfg_wr_en) begin
      len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_mem[pos_eff] <= in_item.sample;
    end
    if (cmd.issue) begin
      rd_data_r <= sample_mem[rd_addr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r   <= '0;
      run_r    <= '0;
      rem_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.accept) begin
        wpos_r <= pos_inc;
        run_r  <= run_nxt;
        rem_r  <= item_ok ? len_r - LEN_BITS'(1) : '0;
      end else if (cmd.issue) begin
        rem_r <= rem_r - LEN_BITS'(1);
      end
    end
  end

  // the current sample is counted as equal up front; the scan covers the rest
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_r     <= in_item.sample;
      rd_addr_r <= pos_eff;
      ok_r      <= item_ok;
      less_r    <= '0;
      eq_r      <= CW'(1);
    end else begin
      if (cmd.issue) begin
        rd_addr_r <= rd_addr_nxt;
      end
      if (rd_vld_r) begin
        if (rd_data_r < cur_r) begin
          less_r <= less_r + CW'(1);
        end else if (rd_data_r == cur_r) begin
          eq_r <= eq_r + CW'(1);
        end
      end
    end
  end

  assign rank_sum = (SW'(less_r) << 1) + SW'(eq_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_item_r.rank_doubled_count <= ok_r ? rank_sum[RANK_BITS-1:0] : '0;
      out_item_r.rank_valid         <= ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.item_ok   = item_ok;
  assign sts.scan_done = (rem_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_item  = out_item_r;
  assign out_valid = out_valid_r;

endmodule

/* bench/rolling_window_percent_rank_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rolling_window_percent_rank_tb
// Drives sample items with random gaps on both channels and checks every
// rank against a typed value from the table or a model of the trailing window
// kept in the bench. A short table of hand-picked items comes first, then
// long series of random samples under several window lengths, including
// zero and lengths beyond the store.
// ---------------------------------------------------------------------------
module rolling_window_percent_rank_tb;
  import rwpr_pkg::*;

  localparam int WMAX       = WINDOW_MAX_DEF;
  localparam int RAND_ITEMS = 950;
  localparam int MAX_GAP    = 18;
  localparam int LONG_HOLD  = 400;
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = 32'sh8000_0000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {VAL_FULL, VAL_NARROW, VAL_EDGE} val_mode_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [LEN_BITS-1:0]           len;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          fin;
    logic                          start;
    logic                          chk;
    logic [RANK_BITS-1:0]          cnt;
    logic                          vld;
  } dir_row_t;

  localparam int DIR_ROWS = 26;
  // kind, len, sample, finite, start, typed, count, valid
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_ITEM, 7'd0,   32'sd0,  1'b1, 1'b0, 1'b1, 8'd0, 1'b0},  // short series
    '{ROW_CFG,  7'd1,   32'sd0,  1'b0, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   SMAX,    1'b1, 1'b1, 1'b1, 8'd1, 1'b1},
    '{ROW_ITEM, 7'd0,   SMIN,    1'b1, 1'b0, 1'b1, 8'd1, 1'b1},
    '{ROW_ITEM, 7'd0,   32'sd5,  1'b0, 1'b0, 1'b1, 8'd0, 1'b0},  // not finite
    '{ROW_ITEM, 7'd0,   -32'sd7, 1'b1, 1'b1, 1'b1, 8'd1, 1'b1},
    '{ROW_CFG,  7'd2,   32'sd0,  1'b0, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   SMIN,    1'b1, 1'b1, 1'b1, 8'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   SMAX,    1'b1, 1'b0, 1'b1, 8'd3, 1'b1},
    '{ROW_ITEM, 7'd0,   SMAX,    1'b1, 1'b0, 1'b1, 8'd2, 1'b1},  // tie
    '{ROW_ITEM, 7'd0,   -32'sd1, 1'b1, 1'b0, 1'b1, 8'd1, 1'b1},  // signed order
    '{ROW_ITEM, 7'd0,   32'sd0,  1'b0, 1'b0, 1'b1, 8'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'sd0,  1'b1, 1'b0, 1'b1, 8'd0, 1'b0},  // NaN in window
    '{ROW_ITEM, 7'd0,   32'sd0,  1'b1, 1'b0, 1'b1, 8'd2, 1'b1},
    '{ROW_ITEM, 7'd0,   32'sd0,  1'b0, 1'b1, 1'b1, 8'd0, 1'b0},  // start on NaN
    '{ROW_CFG,  7'd3,   32'sd0,  1'b0, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'sd5,  1'b1, 1'b1, 1'b0, 8'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'sd9,  1'b1, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'sd5,  1'b1, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'sd7,  1'b1, 1'b0, 1'b0, 8'd0, 1'b0},
    '{ROW_CFG,  7'd0,   32'sd0,  1'b0, 1'b0, 1'b0, 8'd0, 1'b0},  // zero length
    '{ROW_ITEM, 7'd0,   32'sd4,  1'b1, 1'b1, 1'b1, 8'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'sd4,  1'b1, 1'b0, 1'b1, 8'd0, 1'b0},
    '{ROW_CFG,  7'd127, 32'sd0,  1'b0, 1'b0, 1'b0, 8'd0, 1'b0},  // beyond store
    '{ROW_ITEM, 7'd0,   32'sd4,  1'b1, 1'b1, 1'b1, 8'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'sd4,  1'b1, 1'b0, 1'b1, 8'd0, 1'b0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                cfg_wr_en = 1'b0;
  logic [LEN_BITS-1:0] cfg_wr_data = '0;

  // window model
  logic signed [SAMPLE_BITS-1:0] hist_sample [WMAX];
  bit                            hist_finite [WMAX];
  int                            wr_ptr = 0;
  int                            seen_cnt = 0;
  int                            win_len = int'(LEN_RESET);

  out_item_t pending_ranks [$];
  int        mismatches = 0;
  bit        quiet = 1'b0;
  int        hold_len = 0;

  rolling_window_percent_rank u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Store the sample, then rank it against the trailing window.
  function automatic out_item_t rank_of_sample(in_item_t it);
    out_item_t r;
    int        less_cnt;
    int        eq_cnt;
    int        idx;
    bit        ok;
    if (it.series_start) begin
      foreach (hist_finite[i]) hist_finite[i] = 1'b0;
      wr_ptr   = 0;
      seen_cnt = 0;
    end
    hist_sample[wr_ptr] = it.sample;
    hist_finite[wr_ptr] = it.sample_finite;
    if (seen_cnt < int'(RUN_SAT)) seen_cnt++;
    ok = it.sample_finite && win_len >= 1 && win_len <= WMAX && seen_cnt >= win_len;
    less_cnt = 0;
    eq_cnt   = 0;
    if (ok) begin
      for (int k = 0; k < win_len; k++) begin
        idx = (wr_ptr + WMAX - k) % WMAX;
        if (!hist_finite[idx]) begin
          ok = 1'b0;
          break;
        end
        if (hist_sample[idx] < it.sample) less_cnt++;
        else if (hist_sample[idx] == it.sample) eq_cnt++;
      end
    end
    wr_ptr = (wr_ptr + 1) % WMAX;
    r.rank_valid         = ok;
    r.rank_doubled_count = ok ? RANK_BITS'(2 * less_cnt + eq_cnt) : '0;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(val_mode_t m);
    case (m)
      VAL_NARROW: return $signed($urandom_range(0, 6)) - 3;
      VAL_EDGE: begin
        case ($urandom_range(0, 5))
          0: return SMIN;
          1: return SMIN + 1;
          2: return -32'sd1;
          3: return 32'sd0;
          4: return SMAX - 1;
          default: return SMAX;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_rank);
    int        gap;
    out_item_t pred;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    pred = rank_of_sample(it);
    pending_ranks.insert(pending_ranks.size(), typed ? typed_rank : pred);
  endtask

  // Hold off the sender until every pending rank has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
  endtask

  task automatic set_window(input logic [LEN_BITS-1:0] len);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_len = int'(len);
  endtask

  initial begin : stimulus
    dir_row_t            row;
    in_item_t            it;
    out_item_t           typed_rank;
    logic [LEN_BITS-1:0] len;
    int                  sent;
    int                  n_items;
    bit                  start;
    bit                  noisy;
    val_mode_t           vmode;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_tab[r];
      if (row.kind == ROW_CFG) begin
        set_window(row.len);
      end else begin
        it.sample                     = row.sample;
        it.sample_finite              = row.fin;
        it.series_start               = row.start;
        typed_rank.rank_doubled_count = row.cnt;
        typed_rank.rank_valid         = row.vld;
        send_item(it, row.chk, typed_rank);
      end
    end

    sent  = 0;
    noisy = 1'b0;
    vmode = VAL_FULL;
    for (int phase = 0; sent < RAND_ITEMS; phase++) begin
      case (phase)
        0: len = 7'd64;
        1: len = 7'd1;
        2: len = 7'd0;
        3: len = 7'd127;
        default: begin
          case ($urandom_range(0, 9))
            0: len = 7'd0;
            1: len = LEN_BITS'($urandom_range(WMAX + 1, 127));
            2: len = 7'd64;
            3: len = 7'd1;
            default: len = LEN_BITS'($urandom_range(1, WMAX));
          endcase
        end
      endcase
      set_window(len);
      quiet = (phase == 1) || ($urandom_range(0, 4) == 0);
      if (phase == 4) hold_len = LONG_HOLD;
      // one long clean phase: wraps the store and may saturate the run count
      if (phase == 0) n_items = 150;
      else if (len >= 1 && len <= WMAX) n_items = int'(len) + $urandom_range(10, 60);
      else n_items = $urandom_range(10, 25);

      for (int k = 0; k < n_items; k++) begin
        if (k == 0) start = (phase == 0) || ($urandom_range(0, 9) != 0);
        else start = ($urandom_range(0, 79) == 0);
        if (start) begin
          vmode = val_mode_t'($urandom_range(0, 2));
          noisy = (phase != 0) && ($urandom_range(0, 3) == 0);
        end
        it.series_start  = start;
        it.sample_finite = noisy ? ($urandom_range(0, 14) != 0) : 1'b1;
        it.sample        = draw_sample(vmode);
        if (phase == 5 && k == n_items / 2) drain();
        send_item(it, 1'b0, '0);
        sent++;
      end
    end

    drain();
    quiet = 1'b1;
    repeat (2 * WMAX + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("rolling_window_percent_rank_tb: PASS");
    end else begin
      $display("rolling_window_percent_rank_tb: FAIL");
    end
    $finish;
  end

  initial begin : receiver
    int n;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
      end else begin
        n = quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : out_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ranks.size() == 0) begin
        $error("rank with no item pending: count %0d valid %0d",
               out_item.rank_doubled_count, out_item.rank_valid);
        mismatches++;
      end else begin
        want = pending_ranks.pop_front();
        if (out_item.rank_valid !== want.rank_valid) begin
          $error("rank_valid: expected %0d, got %0d", want.rank_valid, out_item.rank_valid);
          mismatches++;
        end
        if (out_item.rank_doubled_count !== want.rank_doubled_count) begin
          $error("rank_doubled_count: expected %0d, got %0d",
                 want.rank_doubled_count, out_item.rank_doubled_count);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("rolling_window_percent_rank_tb: FAIL");
    $finish;
  end

endmodule
